/* rtl/bba_pkg.sv */
package bba_pkg;

  localparam int MemoryBytesDef   = 65536;
  localparam int MinChunkBytesDef = 512;
  localparam int HeaderBytesDef   = 8;

  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic [ApbAddrW-3:0] REG_BASE_ADDRESS = '0;

  localparam int ReqW = 17;
  localparam int AddrW = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR,
    OP_LOAD,
    OP_SIZE,
    OP_SCAN,
    OP_SPLIT,
    OP_TAKE,
    OP_FREAD,
    OP_FCHK,
    OP_MRD,
    OP_MCHK,
    OP_FEND,
    OP_NOSPACE,
    OP_NOTFOUND,
    OP_OUT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_SIZE,
    S_SCAN,
    S_SPLIT,
    S_TAKE,
    S_FREE0,
    S_FCHK,
    S_MRD,
    S_MCHK,
    S_FEND,
    S_DONE
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic size_ge;
    logic k_top;
    logic hit;
    logic scan_end;
    logic have;
    logic split_done;
    logic free_bad;
    logic rd_start;
    logic merge_ok;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/bba_if.sv */
interface bba_in_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [ReqW-1:0]  request_bytes;
  logic [AddrW-1:0] pointer;
  modport source (output valid, mode, request_bytes, pointer, input ready);
  modport sink (input valid, mode, request_bytes, pointer, output ready);
endinterface

interface bba_out_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] result_address;
  logic [1:0]       status;
  modport source (output valid, result_address, status, input ready);
  modport sink (input valid, result_address, status, output ready);
endinterface

/* rtl/bba_ctrl.sv */
module bba_ctrl
  import bba_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_mode_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.op = OP_CLR;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = in_mode_i ? S_FREE0 : S_SIZE;
        end
      end
      S_SIZE: begin
        if (status_i.size_ge) begin
          state_d = S_SCAN;
        end else if (status_i.k_top) begin
          cmd_o.op = OP_NOSPACE;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_SIZE;
        end
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (status_i.hit) begin
          state_d = S_TAKE;
        end else if (status_i.scan_end) begin
          if (status_i.have) begin
            state_d = S_SPLIT;
          end else begin
            cmd_o.op = OP_NOSPACE;
            state_d  = S_DONE;
          end
        end
      end
      S_SPLIT: begin
        cmd_o.op = OP_SPLIT;
        if (status_i.split_done) state_d = S_TAKE;
      end
      S_TAKE: begin
        cmd_o.op = OP_TAKE;
        state_d  = S_DONE;
      end
      S_FREE0: begin
        if (status_i.free_bad) begin
          cmd_o.op = OP_NOTFOUND;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_FREAD;
          state_d  = S_FCHK;
        end
      end
      S_FCHK: begin
        if (!status_i.rd_start) begin
          cmd_o.op = OP_NOTFOUND;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_FCHK;
          state_d  = S_MRD;
        end
      end
      S_MRD: begin
        if (status_i.k_top) begin
          state_d = S_FEND;
        end else begin
          cmd_o.op = OP_MRD;
          state_d  = S_MCHK;
        end
      end
      S_MCHK: begin
        if (status_i.merge_ok) begin
          cmd_o.op = OP_MCHK;
          state_d  = S_MRD;
        end else begin
          state_d = S_FEND;
        end
      end
      S_FEND: begin
        cmd_o.op = OP_FEND;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* rtl/bba_dp.sv */
module bba_dp
  import bba_pkg::*;
#(
  parameter int MemoryBytes   = MemoryBytesDef,
  parameter int MinChunkBytes = MinChunkBytesDef,
  parameter int HeaderBytes   = HeaderBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o,
  input  logic [AddrW-1:0] base_i,
  input  logic             in_mode_i,
  input  logic [ReqW-1:0]  in_req_i,
  input  logic [AddrW-1:0] in_ptr_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [AddrW-1:0] out_addr_o,
  output logic [1:0]       out_status_o
);

  localparam int UnitCount = MemoryBytes / MinChunkBytes;
  localparam int TopOrder  = (UnitCount < 2) ? 0 : $clog2(UnitCount + 1) - 1;
  localparam int Limit     = 1 << TopOrder;
  localparam int AW        = (TopOrder > 0) ? TopOrder : 1;
  localparam int OW        = ($clog2(TopOrder + 1) > 0) ? $clog2(TopOrder + 1) : 1;
  localparam int EW        = OW + 2;
  localparam int Shift     = $clog2(MinChunkBytes);
  localparam int NeedW     = ReqW + 1;

  logic [EW-1:0] mem_q [Limit];
  logic [EW-1:0] rd_q;

  logic [AW:0]       cnt_q, cnt_d;
  logic              rd_v_q, rd_v_d;
  logic              have_q, have_d;
  logic              out_v_q, out_v_d;
  logic [AW-1:0]     ev_u_q, ev_u_d;
  logic [AW-1:0]     best_q, best_d;
  logic [AW-1:0]     u_q, u_d;
  logic [OW-1:0]     k_q, k_d;
  logic [OW-1:0]     cur_q, cur_d;
  logic [NeedW-1:0]  need_q, need_d;
  logic [AddrW-1:0]  loc_q, loc_d;
  logic [AddrW-1:0]  res_addr_q, res_addr_d;
  status_e           res_st_q, res_st_d;
  logic [AddrW-1:0]  out_addr_q, out_addr_d;
  status_e           out_st_q, out_st_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  logic          rd_start, rd_taken;
  logic [OW-1:0] rd_ord, ord_m1;
  logic [AW-1:0] buddy;
  logic          larger;

  assign rd_start = rd_q[EW-1];
  assign rd_taken = rd_q[EW-2];
  assign rd_ord   = rd_q[OW-1:0];
  assign ord_m1   = cur_q - OW'(1);
  assign buddy    = u_q ^ (AW'(1) << k_q);
  assign larger   = rd_v_q && rd_start && !rd_taken && (rd_ord > k_q) &&
                    (!have_q || (rd_ord < cur_q));

  always_comb begin
    status_o.clr_last   = (cnt_q == (AW + 1)'(Limit - 1));
    status_o.size_ge    = ((32'(MinChunkBytes) << k_q) >= 32'(need_q));
    status_o.k_top      = (32'(k_q) >= 32'(TopOrder));
    status_o.hit        = rd_v_q && rd_start && !rd_taken && (rd_ord == k_q);
    status_o.scan_end   = (cnt_q == (AW + 1)'(Limit)) && !rd_v_q;
    status_o.have       = have_q;
    status_o.split_done = (cur_q == k_q);
    status_o.free_bad   = (loc_q[Shift-1:0] != '0) ||
                          ((loc_q >> Shift) >= 32'(Limit));
    status_o.rd_start   = rd_start;
    status_o.merge_ok   = rd_start && !rd_taken && (rd_ord == k_q);
    status_o.out_free   = !out_v_q || out_ready_i;
  end

  always_comb begin
    cnt_d      = cnt_q;
    rd_v_d     = 1'b0;
    have_d     = have_q;
    out_v_d    = out_v_q && !out_ready_i;
    ev_u_d     = ev_u_q;
    best_d     = best_q;
    u_d        = u_q;
    k_d        = k_q;
    cur_d      = cur_q;
    need_d     = need_q;
    loc_d      = loc_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    out_addr_d = out_addr_q;
    out_st_d   = out_st_q;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = '0;
    raddr      = '0;
    wdata      = '0;
    unique case (cmd_i.op)
      OP_NOP: ;
      OP_CLR: begin
        we    = 1'b1;
        waddr = cnt_q[AW-1:0];
        wdata = (cnt_q == '0) ? {1'b1, 1'b0, OW'(TopOrder)} : '0;
        cnt_d = cnt_q + 1'b1;
      end
      OP_LOAD: begin
        need_d = NeedW'(in_req_i) + NeedW'(HeaderBytes);
        loc_d  = in_ptr_i - base_i - AddrW'(HeaderBytes);
        k_d    = '0;
        cnt_d  = '0;
        have_d = 1'b0;
        res_st_d = in_mode_i ? ST_OK : ST_NOSPACE;
      end
      OP_SIZE: k_d = k_q + 1'b1;
      OP_SCAN: begin
        if (cnt_q < (AW + 1)'(Limit)) begin
          re     = 1'b1;
          raddr  = cnt_q[AW-1:0];
          rd_v_d = 1'b1;
          ev_u_d = cnt_q[AW-1:0];
          cnt_d  = cnt_q + 1'b1;
        end
        if (status_o.hit) begin
          best_d = ev_u_q;
          cur_d  = k_q;
        end else if (larger) begin
          best_d = ev_u_q;
          cur_d  = rd_ord;
          have_d = 1'b1;
        end
      end
      OP_SPLIT: begin
        if (!status_o.split_done) begin
          we    = 1'b1;
          waddr = best_q + (AW'(1) << ord_m1);
          wdata = {1'b1, 1'b0, ord_m1};
          cur_d = ord_m1;
        end
      end
      OP_TAKE: begin
        we         = 1'b1;
        waddr      = best_q;
        wdata      = {1'b1, 1'b1, k_q};
        res_addr_d = base_i + AddrW'(HeaderBytes) + (AddrW'(best_q) << Shift);
        res_st_d   = ST_OK;
      end
      OP_FREAD: begin
        re    = 1'b1;
        raddr = loc_q[Shift +: AW];
        u_d   = loc_q[Shift +: AW];
      end
      OP_FCHK: k_d = rd_ord;
      OP_MRD: begin
        re    = 1'b1;
        raddr = buddy;
      end
      OP_MCHK: begin
        we    = 1'b1;
        waddr = u_q | (AW'(1) << k_q);
        wdata = '0;
        u_d   = u_q & ~(AW'(1) << k_q);
        k_d   = k_q + 1'b1;
      end
      OP_FEND: begin
        we         = 1'b1;
        waddr      = u_q;
        wdata      = {1'b1, 1'b0, k_q};
        res_addr_d = '0;
        res_st_d   = ST_OK;
      end
      OP_NOSPACE: begin
        res_addr_d = '0;
        res_st_d   = ST_NOSPACE;
      end
      OP_NOTFOUND: begin
        res_addr_d = '0;
        res_st_d   = ST_NOTFOUND;
      end
      OP_OUT: begin
        out_v_d    = 1'b1;
        out_addr_d = res_addr_q;
        out_st_d   = res_st_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      rd_v_q  <= 1'b0;
      have_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      rd_v_q  <= rd_v_d;
      have_q  <= have_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_u_q     <= ev_u_d;
    best_q     <= best_d;
    u_q        <= u_d;
    k_q        <= k_d;
    cur_q      <= cur_d;
    need_q     <= need_d;
    loc_q      <= loc_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    out_addr_q <= out_addr_d;
    out_st_q   <= out_st_d;
  end

  assign out_valid_o  = out_v_q;
  assign out_addr_o   = out_addr_q;
  assign out_status_o = out_st_q;

endmodule

/* rtl/buddy_block_allocator_top.sv */
// Channel  Dir  Payload                           Handshake
// in_i     in   mode, request_bytes, pointer       valid/ready
// out_o    out  result_address, status            valid/ready
// apb      in   base_address (reg 0)              psel/penable, pready=1
//
// One transaction at a time. Allocate: sizing steps, a scan over the unit memory
// (one read port), one split step per level, then take and result. Free: read
// and check of the block, a buddy read and check per merge, then write-back.
// After reset a clearing pass over the unit memory runs before in_i.ready rises.
// A finished result waits in the output register; the next transaction is taken
// meanwhile, and only its completion waits for out_o.ready.
module buddy_block_allocator_top
  import bba_pkg::*;
#(
  parameter int MemoryBytes   = MemoryBytesDef,
  parameter int MinChunkBytes = MinChunkBytesDef,
  parameter int HeaderBytes   = HeaderBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bba_in_if.sink              in_i,
  bba_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [AddrW-1:0] base_q;
  dp_cmd_t          cmd;
  dp_status_t       status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[ApbAddrW-1:2] == REG_BASE_ADDRESS)) begin
      base_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[ApbAddrW-1:2] == REG_BASE_ADDRESS) ? base_q : '0;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bba_dp #(
    .MemoryBytes   (MemoryBytes),
    .MinChunkBytes (MinChunkBytes),
    .HeaderBytes   (HeaderBytes)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .base_i       (base_q),
    .in_mode_i    (in_i.mode),
    .in_req_i     (in_i.request_bytes),
    .in_ptr_i     (in_i.pointer),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_addr_o   (out_o.result_address),
    .out_status_o (out_o.status)
  );

endmodule
